// ----- sv/c2d_pkg.sv -----
// Shared types and constants for the 3x3 valid convolution block.
// Used by every module of the block but c2d_ram and the checker; depends on nothing.
`default_nettype none

package c2d_pkg;

	localparam int KSIZE       = 3;
	localparam int WIN_N       = KSIZE * KSIZE;
	localparam int PIX_W       = 16;
	localparam int TAP_W       = 16;
	localparam int KROW_W      = KSIZE * TAP_W;
	localparam int PROD_W      = PIX_W + TAP_W;
	localparam int ROW_W       = PROD_W + 2;
	localparam int SUM_W       = PIX_W + 19;
	localparam int POS_W       = 6;
	localparam int SIZE_REG_W  = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = KROW_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(6);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_ROW0 = 2'd0,
		REG_KERNEL_ROW1 = 2'd1,
		REG_KERNEL_ROW2 = 2'd2,
		REG_IMAGE_SIZE  = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [KSIZE-1:0][KROW_W-1:0] rows;
	} kernel_t;

	typedef struct packed {
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             last;
	} meta_t;

	// window pixel (i, j) sits at index i * KSIZE + j
	typedef struct packed {
		logic [WIN_N-1:0][PIX_W-1:0] pix;
		meta_t                       meta;
	} win_item_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage

`default_nettype wire

// ----- sv/c2d_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- sv/c2d_front.sv -----
// Front end: accepts pixels, tracks raster position, runs the line stores and
// the 3x3 window, and pushes full windows into the queue. Uses c2d_pkg, c2d_ram.
`default_nettype none

module c2d_front #(
	parameter int MAX_IMAGE_SIZE = 64
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire signed [c2d_pkg::PIX_W-1:0]   pixel_value,
	input  wire                               start_of_image,
	input  wire [c2d_pkg::SIZE_REG_W-1:0]     image_size,
	input  c2d_pkg::q_status_t                q_status,
	output logic                              push,
	output c2d_pkg::win_item_t                push_item
);

	localparam int ADDR_W = $clog2(MAX_IMAGE_SIZE);
	localparam int SIZE_W = $clog2(MAX_IMAGE_SIZE + 1);

	logic                  accept;
	logic [SIZE_W-1:0]     eff_size;
	logic [ADDR_W-1:0]     row_q, col_q;
	logic [ADDR_W-1:0]     r_in, c_in;
	logic                  col_wrap, row_wrap;
	logic                  emit_in, last_in;

	logic                          valid_s1;
	logic [c2d_pkg::PIX_W-1:0]     px_s1;
	logic [ADDR_W-1:0]             c_s1;
	logic                          emit_s1;
	c2d_pkg::meta_t                meta_s1;
	logic                          fwd_s1;
	logic [c2d_pkg::PIX_W-1:0]     fwd_older_s1, fwd_newer_s1;

	logic [c2d_pkg::PIX_W-1:0]     older_rdata, newer_rdata;
	logic [c2d_pkg::PIX_W-1:0]     col_older, col_newer;

	logic [c2d_pkg::PIX_W-1:0] win_q    [c2d_pkg::KSIZE][c2d_pkg::KSIZE];
	logic [c2d_pkg::PIX_W-1:0] win_next [c2d_pkg::KSIZE][c2d_pkg::KSIZE];

	assign accept = in_valid && !in_stall;

	// room for this pixel, the one in flight and those already queued
	assign in_stall = (32'(q_status.count) + 32'(valid_s1)) >= 32'(c2d_pkg::QUEUE_DEPTH);

	always_comb begin
		if (32'(image_size) < 32'(c2d_pkg::KSIZE)) begin
			eff_size = SIZE_W'(c2d_pkg::KSIZE);
		end else if (32'(image_size) > 32'(MAX_IMAGE_SIZE)) begin
			eff_size = SIZE_W'(MAX_IMAGE_SIZE);
		end else begin
			eff_size = SIZE_W'(image_size);
		end
	end

	always_comb begin
		r_in     = start_of_image ? '0 : row_q;
		c_in     = start_of_image ? '0 : col_q;
		col_wrap = (SIZE_W'(c_in) + SIZE_W'(1)) >= eff_size;
		row_wrap = (SIZE_W'(r_in) + SIZE_W'(1)) >= eff_size;
		emit_in  = (32'(r_in) >= 32'd2) && (32'(c_in) >= 32'd2);
		last_in  = (SIZE_W'(r_in) == eff_size - SIZE_W'(1))
		        && (SIZE_W'(c_in) == eff_size - SIZE_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : r_in + ADDR_W'(1);
			end else begin
				col_q <= c_in + ADDR_W'(1);
				row_q <= r_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1            <= pixel_value;
			c_s1             <= c_in;
			emit_s1          <= emit_in;
			meta_s1.out_row  <= c2d_pkg::POS_W'(32'(r_in) - 32'd2);
			meta_s1.out_col  <= c2d_pkg::POS_W'(32'(c_in) - 32'd2);
			meta_s1.last     <= last_in;
			// same column as the write now under way: the RAM returns stale data
			fwd_s1           <= valid_s1 && (c_in == c_s1);
			fwd_older_s1     <= col_newer;
			fwd_newer_s1     <= px_s1;
		end
	end

	assign col_older = fwd_s1 ? fwd_older_s1 : older_rdata;
	assign col_newer = fwd_s1 ? fwd_newer_s1 : newer_rdata;

	c2d_ram #(
		.WIDTH(c2d_pkg::PIX_W),
		.DEPTH(MAX_IMAGE_SIZE)
	) u_line_older (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(c_s1),
		.wdata(col_newer),
		.raddr(c_in),
		.rdata(older_rdata)
	);

	c2d_ram #(
		.WIDTH(c2d_pkg::PIX_W),
		.DEPTH(MAX_IMAGE_SIZE)
	) u_line_newer (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(c_s1),
		.wdata(px_s1),
		.raddr(c_in),
		.rdata(newer_rdata)
	);

	// shift the window left and bring in the new column
	always_comb begin
		for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
			for (int j = 0; j < c2d_pkg::KSIZE - 1; j++) begin
				win_next[i][j] = win_q[i][j+1];
			end
		end
		win_next[0][c2d_pkg::KSIZE-1] = col_older;
		win_next[1][c2d_pkg::KSIZE-1] = col_newer;
		win_next[2][c2d_pkg::KSIZE-1] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
				for (int j = 0; j < c2d_pkg::KSIZE; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (valid_s1) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		push           = valid_s1 && emit_s1;
		push_item.meta = meta_s1;
		for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
			for (int j = 0; j < c2d_pkg::KSIZE; j++) begin
				push_item.pix[i*c2d_pkg::KSIZE+j] = win_next[i][j];
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/c2d_queue.sv -----
// Short window queue between front end and multiply-accumulate back end.
// Uses c2d_pkg for the entry type and depth.
`default_nettype none

module c2d_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  c2d_pkg::win_item_t  push_item,
	input  wire                 pop,
	output logic                head_valid,
	output c2d_pkg::win_item_t  head_item,
	output c2d_pkg::q_status_t  status
);

	c2d_pkg::win_item_t           entries_q [c2d_pkg::QUEUE_DEPTH];
	logic [c2d_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [c2d_pkg::QCNT_W-1:0]   count_q;
	logic                         do_pop;

	assign head_valid   = count_q != '0;
	assign head_item    = entries_q[rd_ptr_q];
	assign do_pop       = pop && head_valid;
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + c2d_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + c2d_pkg::QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + c2d_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - c2d_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/c2d_back.sv -----
// Back end: nine parallel multipliers, registered row sums, final sum and the
// output register. Uses c2d_pkg.
`default_nettype none

module c2d_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  c2d_pkg::kernel_t                   kernel,
	input  wire                                head_valid,
	input  c2d_pkg::win_item_t                 head_item,
	output logic                               pop,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [c2d_pkg::SUM_W-1:0]   conv_value,
	output logic [c2d_pkg::POS_W-1:0]          out_row,
	output logic [c2d_pkg::POS_W-1:0]          out_col,
	output logic                               last_result
);

	logic advance;

	logic                               valid_s1, valid_s2, out_valid_q;
	logic signed [c2d_pkg::PROD_W-1:0]  prod_s1 [c2d_pkg::WIN_N];
	logic signed [c2d_pkg::ROW_W-1:0]   row_s2  [c2d_pkg::KSIZE];
	logic signed [c2d_pkg::SUM_W-1:0]   sum_q;
	c2d_pkg::meta_t                     meta_s1, meta_s2, meta_q;

	logic signed [c2d_pkg::PIX_W-1:0]   pix_w [c2d_pkg::WIN_N];
	logic signed [c2d_pkg::TAP_W-1:0]   tap_w [c2d_pkg::WIN_N];

	// whole pipeline moves together; hold everything while the output stalls
	assign advance = !out_valid_q || !out_stall;
	assign pop     = head_valid && advance;

	always_comb begin
		for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
			for (int j = 0; j < c2d_pkg::KSIZE; j++) begin
				pix_w[i*c2d_pkg::KSIZE+j] = head_item.pix[i*c2d_pkg::KSIZE+j];
				tap_w[i*c2d_pkg::KSIZE+j] = kernel.rows[i][j*c2d_pkg::TAP_W +: c2d_pkg::TAP_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < c2d_pkg::WIN_N; k++) begin
				prod_s1[k] <= pix_w[k] * tap_w[k];
			end
			meta_s1 <= head_item.meta;

			for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
				row_s2[i] <= c2d_pkg::ROW_W'(prod_s1[i*c2d_pkg::KSIZE])
				           + c2d_pkg::ROW_W'(prod_s1[i*c2d_pkg::KSIZE+1])
				           + c2d_pkg::ROW_W'(prod_s1[i*c2d_pkg::KSIZE+2]);
			end
			meta_s2 <= meta_s1;

			sum_q  <= c2d_pkg::SUM_W'(row_s2[0]) + c2d_pkg::SUM_W'(row_s2[1])
			        + c2d_pkg::SUM_W'(row_s2[2]);
			meta_q <= meta_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign conv_value  = sum_q;
	assign out_row     = meta_q.out_row;
	assign out_col     = meta_q.out_col;
	assign last_result = meta_q.last;

endmodule

`default_nettype wire

// ----- sv/conv2d_valid_3x3.sv -----
// Top level of the 3x3 valid convolution block: configuration registers and
// the front end, queue and back end. Uses c2d_pkg, c2d_front, c2d_queue, c2d_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one signed pixel per
//   transaction in raster order; start_of_image marks row 0, column 0.
//   Output channel (out_valid / out_stall) carries one result per full 3x3
//   window: the exact 35-bit sum, its output row and column, and
//   last_result on the final window of the image.
//   Configuration: cfg_write with cfg_index selects kernel row 0..2 (three
//   signed 16-bit taps, column 0 in the low bits) or the image size. Write
//   only while no pixels are in flight.
//   Throughput: one pixel per cycle while the receiver does not stall, set by the
//   line-store RAM port pair (one read and one write per pixel) and the nine multipliers.
//   Path: after the edge that accepted its pixel, a result passes the
//   line-store read, queue, product stage, row-sum stage and output register.
//   Reset clears positions, window, queue and pipeline valid bits; kernels
//   go to zero and the image size to 6. Line stores are not cleared.
//   When the receiver stalls, the result holds; the back end holds and the
//   queue fills, and in_stall rises once the queue has no room.
`default_nettype none

module conv2d_valid_3x3 #(
	parameter int MAX_IMAGE_SIZE = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_write,
	input  wire [c2d_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [c2d_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire signed [c2d_pkg::PIX_W-1:0]      pixel_value,
	input  wire                                  start_of_image,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [c2d_pkg::SUM_W-1:0]     conv_value,
	output logic [c2d_pkg::POS_W-1:0]            out_row,
	output logic [c2d_pkg::POS_W-1:0]            out_col,
	output logic                                 last_result
);

	c2d_pkg::kernel_t                      kernel_q;
	logic [c2d_pkg::SIZE_REG_W-1:0]        image_size_q;

	logic                  push, pop, head_valid;
	c2d_pkg::win_item_t    push_item, head_item;
	c2d_pkg::q_status_t    q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q     <= '0;
			image_size_q <= c2d_pkg::SIZE_RESET;
		end else if (cfg_write) begin
			case (c2d_pkg::reg_index_t'(cfg_index))
				c2d_pkg::REG_KERNEL_ROW0: kernel_q.rows[0] <= cfg_data;
				c2d_pkg::REG_KERNEL_ROW1: kernel_q.rows[1] <= cfg_data;
				c2d_pkg::REG_KERNEL_ROW2: kernel_q.rows[2] <= cfg_data;
				c2d_pkg::REG_IMAGE_SIZE:
					image_size_q <= cfg_data[c2d_pkg::SIZE_REG_W-1:0];
				default: ;
			endcase
		end
	end

	c2d_front #(
		.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.pixel_value   (pixel_value),
		.start_of_image(start_of_image),
		.image_size    (image_size_q),
		.q_status      (q_status),
		.push          (push),
		.push_item     (push_item)
	);

	c2d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item),
		.status    (q_status)
	);

	c2d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.kernel     (kernel_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.conv_value (conv_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.last_result(last_result)
	);

endmodule

`default_nettype wire

// ----- sv/c2d_checker.sv -----
// Port-level checks for the 3x3 valid convolution block, bound to its top.
// Depends on conv2d_valid_3x3 for the bind target only.
`default_nettype none

module c2d_checker #(
	parameter int MAX_IMAGE_SIZE = 64
) (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [34:0] conv_value,
	input wire [5:0]  out_row,
	input wire [5:0]  out_col,
	input wire        last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(conv_value)
			&& $stable(out_row) && $stable(out_col) && $stable(last_result))
		else $error("stalled result changed or dropped");

	// the asynchronous reset, not a clock edge, is what clears the output register
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown during reset");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> out_row == out_col)
		else $error("last result of a square image off the diagonal");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (MAX_IMAGE_SIZE > 64)
			|| ((32'(out_row) <= 32'(MAX_IMAGE_SIZE - 3))
			&& (32'(out_col) <= 32'(MAX_IMAGE_SIZE - 3))))
		else $error("output position beyond largest image");

endmodule

bind conv2d_valid_3x3 c2d_checker #(
	.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)
) u_c2d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.conv_value (conv_value),
	.out_row    (out_row),
	.out_col    (out_col),
	.last_result(last_result)
);

`default_nettype wire

// ----- dv/tb_conv2d_valid_3x3.sv -----
// Self-checking testbench for conv2d_valid_3x3: streams images in raster order, predicts
// every 3x3 window sum and checks each result as it leaves the block.
// Depends on c2d_pkg and conv2d_valid_3x3.
`timescale 1ns / 1ps

module tb_conv2d_valid_3x3;

	localparam int MAX_SIDE    = 64;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE      = 10;
	localparam int RANDOM_PIX  = 360;
	localparam int STEADY_FROM = 400;
	localparam int STEADY_TO   = 560;

	typedef struct {
		logic signed [c2d_pkg::SUM_W-1:0] sum;
		logic [c2d_pkg::POS_W-1:0]        row;
		logic [c2d_pkg::POS_W-1:0]        col;
		logic                             last;
	} window_result_t;

	class conv_scoreboard;
		logic [c2d_pkg::KROW_W-1:0]       kernel [c2d_pkg::KSIZE];
		logic [c2d_pkg::SIZE_REG_W-1:0]   side_reg;
		logic signed [c2d_pkg::PIX_W-1:0] row_older [MAX_SIDE];
		logic signed [c2d_pkg::PIX_W-1:0] row_newer [MAX_SIDE];
		logic signed [c2d_pkg::PIX_W-1:0] window [c2d_pkg::KSIZE][c2d_pkg::KSIZE];
		int unsigned                      row_pos;
		int unsigned                      col_pos;
		window_result_t                   expected_windows [$];
		int                               errors;
		int                               pixels;
		int                               windows;
		int                               images;

		function new();
			side_reg = c2d_pkg::SIZE_RESET;
			foreach (kernel[k]) kernel[k] = '0;
			foreach (row_older[c]) begin
				row_older[c] = '0;
				row_newer[c] = '0;
			end
			foreach (window[i, j]) window[i][j] = '0;
			row_pos = 0;
			col_pos = 0;
			errors = 0;
			pixels = 0;
			windows = 0;
			images = 0;
		endfunction

		function void set_reg(c2d_pkg::reg_index_t idx,
				logic [c2d_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				c2d_pkg::REG_KERNEL_ROW0: kernel[0] = data;
				c2d_pkg::REG_KERNEL_ROW1: kernel[1] = data;
				c2d_pkg::REG_KERNEL_ROW2: kernel[2] = data;
				c2d_pkg::REG_IMAGE_SIZE:  side_reg = data[c2d_pkg::SIZE_REG_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_size();
			int unsigned s;
			s = 32'(side_reg);
			if (s < c2d_pkg::KSIZE) s = c2d_pkg::KSIZE;
			if (s > MAX_SIDE) s = MAX_SIDE;
			return s;
		endfunction

		function bit at_image_start();
			return row_pos == 0 && col_pos == 0;
		endfunction

		function int pending();
			return expected_windows.size();
		endfunction

		// Shift the window, pull the new column from the line stores, and queue the sum
		// once the window covers three full rows and columns.
		function void accept_pixel(logic signed [c2d_pkg::PIX_W-1:0] px, logic mark);
			int unsigned    sz;
			int unsigned    r;
			int unsigned    c;
			longint         acc;
			window_result_t w;
			sz = eff_size();
			pixels++;
			if (mark) begin
				row_pos = 0;
				col_pos = 0;
			end
			r = row_pos;
			c = col_pos;
			if (c >= MAX_SIDE) c = MAX_SIDE - 1;
			for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
				window[i][0] = window[i][1];
				window[i][1] = window[i][2];
			end
			window[0][2] = row_older[c];
			window[1][2] = row_newer[c];
			window[2][2] = px;
			row_older[c] = row_newer[c];
			row_newer[c] = px;
			if (r >= 2 && c >= 2) begin
				acc = 0;
				for (int i = 0; i < c2d_pkg::KSIZE; i++)
					for (int j = 0; j < c2d_pkg::KSIZE; j++)
						acc += longint'(window[i][j]) * longint'($signed(
							kernel[i][c2d_pkg::TAP_W*j +: c2d_pkg::TAP_W]));
				w.sum = acc[c2d_pkg::SUM_W-1:0];
				w.row = c2d_pkg::POS_W'(r - 2);
				w.col = c2d_pkg::POS_W'(c - 2);
				w.last = (r == sz - 1) && (c == sz - 1);
				expected_windows.push_back(w);
			end
			// wrap at end of row or image, also when the side shrank under the position
			if (c + 1 >= sz) begin
				col_pos = 0;
				row_pos = (r + 1 >= sz) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
				row_pos = r;
			end
		endfunction

		function void check_window(logic signed [c2d_pkg::SUM_W-1:0] sum,
				logic [c2d_pkg::POS_W-1:0] row, logic [c2d_pkg::POS_W-1:0] col,
				logic last);
			window_result_t w;
			if (expected_windows.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%t: result with nothing pending: sum %0d row %0d col %0d last %0b",
						$realtime, sum, row, col, last);
			end else begin
				w = expected_windows.pop_front();
				windows++;
				if (w.last) images++;
				if (sum !== w.sum || row !== w.row || col !== w.col || last !== w.last) begin
					errors++;
					if (errors <= 10) begin
						$display("%t: mismatch: expected sum %0d row %0d col %0d last %0b",
							$realtime, w.sum, w.row, w.col, w.last);
						$display("%t:           got sum %0d row %0d col %0d last %0b",
							$realtime, sum, row, col, last);
					end
				end
			end
		endfunction
	endclass

	logic                             clk            = 1'b0;
	logic                             arst_n         = 1'b0;
	logic                             cfg_write      = 1'b0;
	c2d_pkg::reg_index_t              cfg_index      = c2d_pkg::REG_KERNEL_ROW0;
	logic [c2d_pkg::CFG_DATA_W-1:0]   cfg_data       = '0;
	logic                             in_valid       = 1'b0;
	logic                             in_stall;
	logic signed [c2d_pkg::PIX_W-1:0] pixel_value    = '0;
	logic                             start_of_image = 1'b0;
	logic                             out_valid;
	logic                             out_stall      = 1'b0;
	logic signed [c2d_pkg::SUM_W-1:0] conv_value;
	logic [c2d_pkg::POS_W-1:0]        out_row;
	logic [c2d_pkg::POS_W-1:0]        out_col;
	logic                             last_result;

	conv_scoreboard board = new();
	bit             steady;
	int             pixels_sent;
	int             reg_writes;

	conv2d_valid_3x3 dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_value    (pixel_value),
		.start_of_image (start_of_image),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.conv_value     (conv_value),
		.out_row        (out_row),
		.out_col        (out_col),
		.last_result    (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 17);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.accept_pixel(pixel_value, start_of_image);
			if (out_valid && !out_stall)
				board.check_window(conv_value, out_row, out_col, last_result);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
				idle = 0;
			else
				idle++;
		end
		$display("conv2d_valid_3x3 regression: fail");
		$finish;
	end

	// Mostly uniform, with the extremes and small values drawn often.
	function automatic logic signed [c2d_pkg::PIX_W-1:0] rand_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) return 16'h8000;
		if (pick < 20) return 16'h7FFF;
		if (pick < 25) return '0;
		if (pick < 35) return c2d_pkg::PIX_W'($urandom_range(8) - 4);
		return c2d_pkg::PIX_W'($urandom());
	endfunction

	function automatic logic [c2d_pkg::CFG_DATA_W-1:0] rand_krow();
		return {rand_sample(), rand_sample(), rand_sample()};
	endfunction

	// Junk above the size field must be ignored.
	function automatic logic [c2d_pkg::CFG_DATA_W-1:0] size_word(input int side);
		logic [c2d_pkg::CFG_DATA_W-1:0] w;
		w = c2d_pkg::CFG_DATA_W'({$urandom(), $urandom()});
		w[c2d_pkg::SIZE_REG_W-1:0] = c2d_pkg::SIZE_REG_W'(side);
		return w;
	endfunction

	task automatic send_pixel(input logic signed [c2d_pkg::PIX_W-1:0] px, input logic mark);
		steady = pixels_sent >= STEADY_FROM && pixels_sent < STEADY_TO;
		while (!steady && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_value <= px;
		start_of_image <= mark;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic stream(input int count, input logic mark_first);
		for (int k = 0; k < count; k++)
			send_pixel(rand_sample(), mark_first && k == 0);
	endtask

	// Hold off until every pending window is out and the pipeline has emptied.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input c2d_pkg::reg_index_t idx,
			input logic [c2d_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.set_reg(idx, data);
		reg_writes++;
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int random_base;
		int side;
		int n;
		int pick;
		pixels_sent = 0;
		reg_writes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: side 6, zero kernel, no start marker needed
		stream(36, 1'b0);

		// largest sum magnitudes, then a restart in the middle of an image
		drain();
		for (int k = 0; k < c2d_pkg::KSIZE; k++)
			write_reg(c2d_pkg::reg_index_t'(k), {c2d_pkg::KSIZE{16'h8000}});
		write_reg(c2d_pkg::REG_IMAGE_SIZE, size_word(0));
		for (int k = 0; k < 9; k++)
			send_pixel(16'h8000, k == 0);
		for (int k = 0; k < 9; k++)
			send_pixel(16'h7FFF, 1'b0);
		stream(4, 1'b1);
		drain();
		write_reg(c2d_pkg::REG_KERNEL_ROW1, {16'h7FFF, 16'h0000, 16'h8000});
		write_reg(c2d_pkg::REG_KERNEL_ROW2, {c2d_pkg::KSIZE{16'h7FFF}});
		stream(9, 1'b1);

		// widest image: oversize register value, then exact maximum, then shrink to the
		// minimum while the position sits far beyond the new side
		drain();
		for (int k = 0; k < c2d_pkg::KSIZE; k++)
			write_reg(c2d_pkg::reg_index_t'(k), rand_krow());
		write_reg(c2d_pkg::REG_IMAGE_SIZE, size_word(127));
		stream(2 * MAX_SIDE, 1'b1);
		drain();
		write_reg(c2d_pkg::REG_IMAGE_SIZE, size_word(MAX_SIDE));
		stream(2 * MAX_SIDE + 40, 1'b0);
		drain();
		write_reg(c2d_pkg::REG_IMAGE_SIZE, size_word(c2d_pkg::KSIZE));
		stream(1 + c2d_pkg::KSIZE * c2d_pkg::KSIZE, 1'b0);

		random_base = pixels_sent;
		while (pixels_sent - random_base < RANDOM_PIX) begin
			drain();
			for (int k = 0; k < c2d_pkg::KSIZE; k++)
				if ($urandom_range(1))
					write_reg(c2d_pkg::reg_index_t'(k), rand_krow());
			if ($urandom_range(3) != 0) begin
				// never grow the side mid-image: stored rows would be short
				if (board.at_image_start()) begin
					pick = $urandom_range(99);
					if (pick < 8) side = $urandom_range(2);
					else if (pick < 85) side = $urandom_range(8, 3);
					else side = $urandom_range(14, 9);
				end else begin
					side = $urandom_range(board.eff_size());
				end
				write_reg(c2d_pkg::REG_IMAGE_SIZE, size_word(side));
			end
			repeat ($urandom_range(3, 1)) begin
				n = board.eff_size() * board.eff_size();
				pick = $urandom_range(99);
				if (pick < 65) stream(n, 1'b1);
				else if (pick < 80) stream(n, 1'b0);
				else stream($urandom_range(n - 1, 1), 1'($urandom_range(1)));
			end
		end

		drain();
		$display("Summary: %0d pixels in, %0d windows checked, %0d images completed",
			board.pixels, board.windows, board.images);
		$display("Summary: %0d register writes, sides from 3 to 64, mid-image shrink and restart",
			reg_writes);
		if (board.errors == 0)
			$display("conv2d_valid_3x3 regression: pass");
		else
			$display("conv2d_valid_3x3 regression: fail");
		$finish;
	end

endmodule
